### hdl/fcg_pkg.sv
package fcg_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int MAX_DIMENSION_DEF = 4096;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int RGB_W      = 24;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [RGB_W-1:0] TOP_LEFT_RST     = 24'hFF0000;
  localparam logic [RGB_W-1:0] TOP_RIGHT_RST    = 24'h0000FF;
  localparam logic [RGB_W-1:0] BOTTOM_RIGHT_RST = 24'h00FF00;
  localparam logic [RGB_W-1:0] BOTTOM_LEFT_RST  = 24'hFFFF00;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_LEFT     = 3'd0,
    REG_TOP_RIGHT    = 3'd1,
    REG_BOTTOM_RIGHT = 3'd2,
    REG_BOTTOM_LEFT  = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } coord_item_t;

  typedef struct packed {
    logic [31:0] argb_word;
    logic        coordinate_clamped;
  } pixel_item_t;

endpackage

### hdl/fcg_recip.sv
module fcg_recip import fcg_pkg::*; #(
  parameter int VW = FRACTION_BITS_DEF + CHAN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIM_W-1:0] divisor,
  output logic             busy,
  output logic [VW:0]      recip
);

  localparam int CNT_W = $clog2(VW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DIM_W-1:0] rem;
  logic [DIM_W:0]   trial;
  logic             bit_in;
  logic             fits;

  // restoring division of 2**VW, one quotient bit a cycle
  always_comb begin
    bit_in = (cnt == CNT_W'(VW));
    trial  = {rem, bit_in};
    fits   = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNT_W'(VW);
      rem <= '0;
    end else if (busy) begin
      cnt   <= cnt - 1'b1;
      rem   <= fits ? DIM_W'(trial - {1'b0, divisor}) : DIM_W'(trial);
      recip <= {recip[VW-1:0], fits};
    end
  end

endmodule

### hdl/fcg_blend.sv
module fcg_blend import fcg_pkg::*; #(
  parameter int CH     = 3,
  parameter int VW     = FRACTION_BITS_DEF + CHAN_W,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CH-1:0][VW-1:0]  a,
  input  logic [CH-1:0][VW-1:0]  b,
  input  logic [COORD_W-1:0]     pos,
  input  logic                   last,
  input  logic [DIM_W-1:0]       d,
  input  logic [VW:0]            recip,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CH-1:0][VW-1:0]  v,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int STAGES = 6;
  localparam int PW     = 2 * VW + 1;
  localparam int QW     = VW + DIM_W;
  localparam int MW     = COORD_W + VW;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;
  logic [STAGES-1:0][SIDE_W-1:0] side_r;

  // stage payloads
  logic [CH-1:0][VW-1:0] a1, b1, mag1;
  logic [CH-1:0]         neg1;
  logic [COORD_W-1:0]    pos1;
  logic                  last1;
  logic [CH-1:0][VW-1:0] a2, b2, mag2, q02;
  logic [CH-1:0]         neg2;
  logic [COORD_W-1:0]    pos2;
  logic                  last2;
  logic [CH-1:0][VW-1:0] a3, b3, mag3, q03, qd3;
  logic [CH-1:0]         neg3;
  logic [COORD_W-1:0]    pos3;
  logic                  last3;
  logic [CH-1:0][VW-1:0] a4, b4, q4;
  logic [CH-1:0]         neg4;
  logic [COORD_W-1:0]    pos4;
  logic                  last4;
  logic [CH-1:0][VW-1:0] a5, b5, m5;
  logic [CH-1:0]         neg5;
  logic                  last5;

  // stage logic
  logic [CH-1:0][VW-1:0] mag0, q0c, qdc, qc, mc, vc;
  logic [CH-1:0]         neg0;

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];
  assign side_out  = side_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_in;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // sign and magnitude of the span
  always_comb begin
    logic [VW:0] diff;
    logic [VW:0] mag_full;
    for (int c = 0; c < CH; c++) begin
      diff     = {1'b0, b[c]} - {1'b0, a[c]};
      neg0[c]  = diff[VW];
      mag_full = diff[VW] ? (~diff + 1'b1) : diff;
      mag0[c]  = mag_full[VW-1:0];
    end
  end

  // quotient estimate from the reciprocal
  always_comb begin
    logic [PW-1:0] prod;
    for (int c = 0; c < CH; c++) begin
      prod   = PW'(mag1[c]) * PW'(recip);
      q0c[c] = prod[2*VW-1:VW];
    end
  end

  always_comb begin
    logic [QW-1:0] qd;
    for (int c = 0; c < CH; c++) begin
      qd     = QW'(q02[c]) * QW'(d);
      qdc[c] = qd[VW-1:0];
    end
  end

  // estimate is low by at most one
  always_comb begin
    logic [VW-1:0] r;
    for (int c = 0; c < CH; c++) begin
      r     = mag3[c] - qd3[c];
      qc[c] = (r >= VW'(d)) ? q03[c] + 1'b1 : q03[c];
    end
  end

  always_comb begin
    logic [MW-1:0] mp;
    for (int c = 0; c < CH; c++) begin
      mp    = MW'(pos4) * MW'(q4[c]);
      mc[c] = mp[VW-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      if (last5) begin
        vc[c] = b5[c];
      end else if (neg5[c]) begin
        vc[c] = a5[c] - m5[c];
      end else begin
        vc[c] = a5[c] + m5[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1    <= a;
      b1    <= b;
      mag1  <= mag0;
      neg1  <= neg0;
      pos1  <= pos;
      last1 <= last;
    end
    if (en[1]) begin
      a2    <= a1;
      b2    <= b1;
      mag2  <= mag1;
      neg2  <= neg1;
      q02   <= q0c;
      pos2  <= pos1;
      last2 <= last1;
    end
    if (en[2]) begin
      a3    <= a2;
      b3    <= b2;
      mag3  <= mag2;
      neg3  <= neg2;
      q03   <= q02;
      qd3   <= qdc;
      pos3  <= pos2;
      last3 <= last2;
    end
    if (en[3]) begin
      a4    <= a3;
      b4    <= b3;
      neg4  <= neg3;
      q4    <= qc;
      pos4  <= pos3;
      last4 <= last3;
    end
    if (en[4]) begin
      a5    <= a4;
      b5    <= b4;
      neg5  <= neg4;
      m5    <= mc;
      last5 <= last4;
    end
    if (en[5]) begin
      v <= vc;
    end
  end

endmodule

### hdl/four_corner_gradient_pixel.sv
// channel  direction  handshake                 payload
// coord    in         coord_valid/coord_stall   coord_item_t (pixel_x, pixel_y)
// pixel    out        pixel_valid/pixel_stall   pixel_item_t (argb_word, coordinate_clamped)
// cfg      in         cfg_write                 cfg_index, cfg_data
//
// one item per cycle while coord_stall is low; clamp stage, six-stage edge blend
// over the rows, six-stage row blend over the columns
// each divide by (size - 1) is a multiply by a stored reciprocal plus one correction
// after reset and after each frame size write the reciprocals are rebuilt,
// with coord_stall high until they are done
// pixel_stall holds only the stages that are full; empty stages keep filling
module four_corner_gradient_pixel import fcg_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  coord_valid,
  output logic                  coord_stall,
  input  coord_item_t           coord,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output pixel_item_t           pixel,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int VW     = FRACTION_BITS + CHAN_W;
  localparam int EDGE_W = COORD_W + 2;

  logic [RGB_W-1:0] top_left_rgb, top_right_rgb, bottom_right_rgb, bottom_left_rgb;
  logic [DIM_W-1:0] frame_width, frame_height;
  logic             restart;

  logic [DIM_W-1:0] w_eff, h_eff, w_div, h_div;
  logic             busy_w, busy_h, busy;
  logic [VW:0]      recip_w, recip_h;

  logic               accept, en0, v0;
  logic [COORD_W-1:0] x_c, y_c, x0, y0;
  logic               clamp_c, xlast_c, ylast_c;
  logic               clamp0, xlast0, ylast0;

  logic                  edge_ready, edge_valid;
  logic [5:0][VW-1:0]    edge_a, edge_b, edge_v;
  logic [EDGE_W-1:0]     edge_side;

  logic                  row_ready, row_valid;
  logic [2:0][VW-1:0]    row_a, row_b, row_v;
  logic                  row_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_left_rgb     <= TOP_LEFT_RST;
      top_right_rgb    <= TOP_RIGHT_RST;
      bottom_right_rgb <= BOTTOM_RIGHT_RST;
      bottom_left_rgb  <= BOTTOM_LEFT_RST;
      frame_width      <= FRAME_WIDTH_RST;
      frame_height     <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOP_LEFT:     top_left_rgb     <= cfg_data;
        REG_TOP_RIGHT:    top_right_rgb    <= cfg_data;
        REG_BOTTOM_RIGHT: bottom_right_rgb <= cfg_data;
        REG_BOTTOM_LEFT:  bottom_left_rgb  <= cfg_data;
        REG_FRAME_WIDTH:  frame_width      <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height     <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
    end else begin
      restart <= cfg_write && (cfg_index == REG_FRAME_WIDTH ||
                               cfg_index == REG_FRAME_HEIGHT);
    end
  end

  always_comb begin
    if (frame_width < DIM_W'(2)) begin
      w_eff = DIM_W'(2);
    end else if (32'(frame_width) > MAX_DIMENSION) begin
      w_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < DIM_W'(2)) begin
      h_eff = DIM_W'(2);
    end else if (32'(frame_height) > MAX_DIMENSION) begin
      h_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      h_eff = frame_height;
    end
    w_div = w_eff - 1'b1;
    h_div = h_eff - 1'b1;
  end

  fcg_recip #(.VW(VW)) u_recip_w (
    .clk     (clk),
    .rst     (rst),
    .start   (restart),
    .divisor (w_div),
    .busy    (busy_w),
    .recip   (recip_w)
  );

  fcg_recip #(.VW(VW)) u_recip_h (
    .clk     (clk),
    .rst     (rst),
    .start   (restart),
    .divisor (h_div),
    .busy    (busy_h),
    .recip   (recip_h)
  );

  assign busy        = restart || busy_w || busy_h;
  assign en0         = !v0 || edge_ready;
  assign coord_stall = busy || !en0;
  assign accept      = coord_valid && !coord_stall;

  // clamp stage
  always_comb begin
    clamp_c = 1'b0;
    x_c     = coord.pixel_x;
    y_c     = coord.pixel_y;
    if ({1'b0, coord.pixel_x} >= w_eff) begin
      x_c     = COORD_W'(w_div);
      clamp_c = 1'b1;
    end
    if ({1'b0, coord.pixel_y} >= h_eff) begin
      y_c     = COORD_W'(h_div);
      clamp_c = 1'b1;
    end
    xlast_c = ({1'b0, x_c} >= w_div);
    ylast_c = ({1'b0, y_c} >= h_div);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x0     <= x_c;
      y0     <= y_c;
      clamp0 <= clamp_c;
      xlast0 <= xlast_c;
      ylast0 <= ylast_c;
    end
  end

  // lanes 0..2 left edge, 3..5 right edge; channel 0 blue, 2 red
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      edge_a[c]   = {top_left_rgb[CHAN_W*c +: CHAN_W], {FRACTION_BITS{1'b0}}};
      edge_b[c]   = {bottom_left_rgb[CHAN_W*c +: CHAN_W], {FRACTION_BITS{1'b0}}};
      edge_a[c+3] = {top_right_rgb[CHAN_W*c +: CHAN_W], {FRACTION_BITS{1'b0}}};
      edge_b[c+3] = {bottom_right_rgb[CHAN_W*c +: CHAN_W], {FRACTION_BITS{1'b0}}};
    end
  end

  fcg_blend #(.CH(6), .VW(VW), .SIDE_W(EDGE_W)) u_edge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (edge_ready),
    .a         (edge_a),
    .b         (edge_b),
    .pos       (y0),
    .last      (ylast0),
    .d         (h_div),
    .recip     (recip_h),
    .side_in   ({x0, xlast0, clamp0}),
    .out_valid (edge_valid),
    .out_ready (row_ready),
    .v         (edge_v),
    .side_out  (edge_side)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      row_a[c] = edge_v[c];
      row_b[c] = edge_v[c+3];
    end
  end

  fcg_blend #(.CH(3), .VW(VW), .SIDE_W(1)) u_row (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edge_valid),
    .in_ready  (row_ready),
    .a         (row_a),
    .b         (row_b),
    .pos       (edge_side[EDGE_W-1:2]),
    .last      (edge_side[1]),
    .d         (w_div),
    .recip     (recip_w),
    .side_in   (edge_side[0]),
    .out_valid (row_valid),
    .out_ready (!pixel_stall),
    .v         (row_v),
    .side_out  (row_clamp)
  );

  assign pixel_valid              = row_valid;
  assign pixel.argb_word          = {ALPHA_OPAQUE,
                                     row_v[2][VW-1:FRACTION_BITS],
                                     row_v[1][VW-1:FRACTION_BITS],
                                     row_v[0][VW-1:FRACTION_BITS]};
  assign pixel.coordinate_clamped = row_clamp;

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fcg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;
  localparam int PIPE_LATENCY    = 13;
  localparam int RUN_LIMIT       = 200000;
  localparam int MISMATCH_SHOW   = 10;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int QUIET_PHASE     = 4;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit                 typed;
    logic [31:0]        argb;
    bit                 clamp;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  coord_valid = 1'b0;
  logic                  coord_stall;
  coord_item_t           coord_in = '0;
  logic                  pixel_valid;
  logic                  pixel_stall = 1'b0;
  pixel_item_t           pixel_out;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // copy of the register file
  logic [RGB_W-1:0] corner_rgb [4] = '{TOP_LEFT_RST, TOP_RIGHT_RST,
                                       BOTTOM_RIGHT_RST, BOTTOM_LEFT_RST};
  logic [DIM_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [DIM_W-1:0] height_reg = FRAME_HEIGHT_RST;

  pixel_item_t pending_pixels [$];
  bit          idling_on = 1'b1;
  int          mismatch_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          clamped_count = 0;
  int          write_count = 0;
  int          setting_count = 0;
  int          cycle_count = 0;

  probe_row_t reset_probes [13] = '{
    '{12'd0,    12'd0,    1'b1, 32'hFFFF0000, 1'b0},
    '{12'd319,  12'd0,    1'b1, 32'hFF0000FF, 1'b0},
    '{12'd319,  12'd239,  1'b1, 32'hFF00FF00, 1'b0},
    '{12'd0,    12'd239,  1'b1, 32'hFFFFFF00, 1'b0},
    '{12'd4095, 12'd4095, 1'b1, 32'hFF00FF00, 1'b1},
    '{12'd4095, 12'd0,    1'b1, 32'hFF0000FF, 1'b1},
    '{12'd0,    12'd4095, 1'b1, 32'hFFFFFF00, 1'b1},
    '{12'd320,  12'd239,  1'b1, 32'hFF00FF00, 1'b1},
    '{12'd1,    12'd1,    1'b0, 32'h0,        1'b0},
    '{12'd160,  12'd120,  1'b0, 32'h0,        1'b0},
    '{12'd318,  12'd238,  1'b0, 32'h0,        1'b0},
    '{12'd341,  12'd170,  1'b0, 32'h0,        1'b0},
    '{12'd170,  12'd341,  1'b0, 32'h0,        1'b0}
  };

  four_corner_gradient_pixel u_top (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .coord       (coord_in),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel_out),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_size(logic [DIM_W-1:0] r);
    int unsigned n;
    n = 32'(r);
    if (n < 2) return 2;
    if (n > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return n;
  endfunction

  function automatic longint lerp_fixed(longint a, longint b, int unsigned pos,
                                        int unsigned n);
    longint step;
    if (pos >= n - 1) return b;
    step = (b - a) / longint'(n - 1);
    return a + longint'(pos) * step;
  endfunction

  function automatic longint lane_fixed(logic [RGB_W-1:0] rgb, int lane);
    return longint'(rgb[8*lane +: 8]) << FRACTION_BITS_DEF;
  endfunction

  function automatic pixel_item_t gradient_pixel(coord_item_t c);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    longint      left;
    longint      right;
    longint      shade;
    pixel_item_t p;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    x = 32'(c.pixel_x);
    y = 32'(c.pixel_y);
    p.argb_word = {ALPHA_OPAQUE, 24'h0};
    p.coordinate_clamped = 1'b0;
    if (x >= w) begin
      x = w - 1;
      p.coordinate_clamped = 1'b1;
    end
    if (y >= h) begin
      y = h - 1;
      p.coordinate_clamped = 1'b1;
    end
    for (int lane = 0; lane < 3; lane++) begin
      left  = lerp_fixed(lane_fixed(corner_rgb[2'(REG_TOP_LEFT)], lane),
                         lane_fixed(corner_rgb[2'(REG_BOTTOM_LEFT)], lane), y, h);
      right = lerp_fixed(lane_fixed(corner_rgb[2'(REG_TOP_RIGHT)], lane),
                         lane_fixed(corner_rgb[2'(REG_BOTTOM_RIGHT)], lane), y, h);
      shade = lerp_fixed(left, right, x, w);
      if (shade < 0) p.argb_word[8*lane +: 8] = 8'h00;
      else if ((shade >>> FRACTION_BITS_DEF) > 255) p.argb_word[8*lane +: 8] = 8'hFF;
      else p.argb_word[8*lane +: 8] = shade[FRACTION_BITS_DEF +: 8];
    end
    return p;
  endfunction

  task automatic check_pixel(pixel_item_t got);
    pixel_item_t want;
    if (pending_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOW)
        $display("unexpected pixel item: argb %h clamped %b", got.argb_word,
                 got.coordinate_clamped);
    end else begin
      want = pending_pixels.pop_front();
      checked_count++;
      if (got.coordinate_clamped) clamped_count++;
      if (got.argb_word !== want.argb_word ||
          got.coordinate_clamped !== want.coordinate_clamped) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOW)
          $display("pixel %0d mismatch: argb exp %h got %h, clamped exp %b got %b",
                   checked_count, want.argb_word, got.argb_word,
                   want.coordinate_clamped, got.coordinate_clamped);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) check_pixel(pixel_out);
      pixel_stall <= idling_on && ($urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               pending_pixels.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    write_count++;
    case (idx)
      REG_TOP_LEFT, REG_TOP_RIGHT, REG_BOTTOM_RIGHT, REG_BOTTOM_LEFT: begin
        corner_rgb[idx[1:0]] = data;
      end
      REG_FRAME_WIDTH: begin
        width_reg = data[DIM_W-1:0];
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[DIM_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input bit typed, input pixel_item_t typed_pixel);
    coord_item_t c;
    c.pixel_x = x;
    c.pixel_y = y;
    while (idling_on && $urandom_range(99) < 11) begin
      coord_valid <= 1'b0;
      @(posedge clk);
    end
    coord_valid <= 1'b1;
    coord_in    <= c;
    @(posedge clk);
    while (coord_stall) @(posedge clk);
    pending_pixels.push_back(typed ? typed_pixel : gradient_pixel(c));
    sent_count++;
  endtask

  // hold off the sender until every pixel is back
  task automatic drain();
    coord_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] size_word(int unsigned size);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[DIM_W-1:0] = DIM_W'(size);
    return d;
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(9))
      0: return $urandom_range(0, 1);
      1: return $urandom_range(MAX_DIMENSION_DEF + 1, 8191);
      2, 3, 4: return $urandom_range(2, 24);
      5: return ($urandom_range(1) != 0) ? MAX_DIMENSION_DEF : 2;
      default: return $urandom_range(2, MAX_DIMENSION_DEF);
    endcase
  endfunction

  function automatic logic [RGB_W-1:0] pick_colour();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return RGB_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_axis(int unsigned size);
    case ($urandom_range(9))
      0: return COORD_W'($urandom);
      1: return (size > 4095) ? 12'hFFF : COORD_W'($urandom_range(size, 4095));
      2: return COORD_W'(size - 1);
      3: return '0;
      default: return COORD_W'($urandom_range(0, size - 1));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    setting_count++;

    foreach (reset_probes[i])
      send_coord(reset_probes[i].x, reset_probes[i].y, reset_probes[i].typed,
                 '{reset_probes[i].argb, reset_probes[i].clamp});

    // width below two, height beyond the maximum, black and white corners
    drain();
    write_reg(REG_FRAME_WIDTH, 24'hFFE000);
    write_reg(REG_FRAME_HEIGHT, 24'h001FFF);
    write_reg(REG_TOP_LEFT, 24'h000000);
    write_reg(REG_TOP_RIGHT, 24'hFFFFFF);
    write_reg(REG_BOTTOM_RIGHT, 24'h000000);
    write_reg(REG_BOTTOM_LEFT, 24'hFFFFFF);
    write_reg(SPARE_INDEX_LO, 24'hFFFFFF);
    write_reg(SPARE_INDEX_HI, 24'h000000);
    cfg_write <= 1'b0;
    setting_count++;
    send_coord(12'd0, 12'd0, 1'b1, '{32'hFF000000, 1'b0});
    send_coord(12'd1, 12'd4095, 1'b1, '{32'hFF000000, 1'b0});
    send_coord(12'd4095, 12'd2048, 1'b0, '0);
    send_coord(12'd0, 12'd2048, 1'b0, '0);

    // widest row, height of one acting as two
    drain();
    write_reg(REG_FRAME_WIDTH, 24'h001000);
    write_reg(REG_FRAME_HEIGHT, 24'h000001);
    write_reg(REG_TOP_LEFT, 24'hFFFFFF);
    write_reg(REG_TOP_RIGHT, 24'h00FF00);
    write_reg(REG_BOTTOM_RIGHT, 24'h0000FF);
    write_reg(REG_BOTTOM_LEFT, 24'h123456);
    cfg_write <= 1'b0;
    setting_count++;
    send_coord(12'd4095, 12'd0, 1'b1, '{32'hFF00FF00, 1'b0});
    send_coord(12'd0, 12'd1, 1'b1, '{32'hFF123456, 1'b0});
    send_coord(12'd4095, 12'd4095, 1'b1, '{32'hFF0000FF, 1'b1});
    send_coord(12'd2048, 12'd1, 1'b0, '0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      idling_on = (ph != QUIET_PHASE);
      for (int r = 0; r <= REG_FRAME_HEIGHT; r++) begin
        if (ph == 0 || $urandom_range(3) != 0) begin
          if (cfg_reg_t'(r) == REG_FRAME_WIDTH || cfg_reg_t'(r) == REG_FRAME_HEIGHT)
            write_reg(cfg_reg_t'(r), size_word(pick_size()));
          else
            write_reg(cfg_reg_t'(r), {pick_colour()});
        end
      end
      if ($urandom_range(1) != 0)
        write_reg(($urandom_range(1) != 0) ? SPARE_INDEX_LO : SPARE_INDEX_HI,
                  CFG_DATA_W'($urandom));
      cfg_write <= 1'b0;
      setting_count++;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_coord(pick_axis(eff_size(width_reg)), pick_axis(eff_size(height_reg)),
                   1'b0, '0);
    end
    idling_on = 1'b1;

    drain();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("%0d coordinate items over %0d frame settings, %0d register writes",
             sent_count, setting_count, write_count);
    $display("%0d pixels checked, %0d clamped, %0d mismatches, %0d outstanding",
             checked_count, clamped_count, mismatch_count, pending_pixels.size());
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
